@@ rtl/core/gakl_pkg.sv @@
// Shared types and constants for the glyph advance and kerning lookup block.
package gakl_pkg;

	localparam int GLYPH_SLOTS = 256;
	localparam int KERN_SLOTS = 1024;

	localparam int GLYPH_AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam int KERN_AW = (KERN_SLOTS > 1) ? $clog2(KERN_SLOTS) : 1;
	localparam int KC_W = $clog2(KERN_SLOTS + 1);
	localparam int PTR_W = (KC_W > 10) ? KC_W : 10;

	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_GLYPH_WR = 2'd1;
	localparam logic [1:0] OP_KERN_WR = 2'd2;

	localparam logic [1:0] REG_FIRST_CODE = 2'd0;
	localparam logic [1:0] REG_GLYPH_COUNT = 2'd1;
	localparam logic [1:0] REG_KERN_COUNT = 2'd2;
	localparam logic [1:0] REG_MISSING_SPACING = 2'd3;

	localparam logic [7:0] CHAR_NUL = 8'd0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [8:0] GLYPH_NONE = 9'h1FF;

	typedef struct packed {
		logic [7:0] width;
		logic [7:0] spacing;
		logic has_kern;
		logic [9:0] kern_start;
	} glyph_entry_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] offset;
	} kern_entry_t;

	typedef struct packed {
		logic en;
		logic [9:0] addr;
		kern_entry_t entry;
	} kern_wr_t;

	typedef struct packed {
		logic load;
		logic [9:0] start;
		logic [7:0] letter;
		logic [7:0] letter2;
		logic [KC_W-1:0] kcount;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic [7:0] offset;
	} scan_res_t;

endpackage

@@ rtl/core/glyph_advance_kerning_lookup.sv @@
// Top level: glyph advance lookup with kerning pair scan for a bitmap font.
//
// Input channel (in_valid/in_ready) carries one transaction per item: a query
// (opcode 0), a glyph table write (opcode 1) or a kerning pair write (opcode 2).
// Writes complete in the accept cycle and give no result. Each query gives one
// result on the output channel (out_valid/out_ready).
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write configuration only while the block is idle.
// Query steps: a character outside the font goes straight to the done state;
// one inside it reads its glyph entry, then runs a kerning scan if the glyph
// has kerning pairs and the next character can be kerned, and then reaches
// the done state, where the result moves into the free output register and
// out_valid rises. A table write leaves the block idle for the next item. The
// scan reads one kerning pair per cycle from a single-port table, and that
// loop sets the query time. in_ready is low from a query's accept until its
// result moves into the output register; an item can be accepted while that
// result still waits for out_ready. A stalled receiver holds the result and,
// once the next query is done, holds the block too.
// Reset clears the configuration registers to zero and empties the output
// register. Table contents are undefined until written.
module glyph_advance_kerning_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        first_char,
	input  logic [7:0]        next_char,
	input  logic [9:0]        entry_index,
	input  logic [7:0]        glyph_width,
	input  logic [7:0]        glyph_spacing,
	input  logic              glyph_has_kern,
	input  logic [9:0]        glyph_kern_start,
	input  logic [7:0]        pair_first,
	input  logic [7:0]        pair_second,
	input  logic signed [7:0] pair_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [8:0] glyph_index,
	output logic [7:0]        char_width,
	output logic signed [9:0] char_spacing,
	output logic              kern_applied,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [10:0]       cfg_data
);
	import gakl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GLYPH = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	logic [7:0] first_code_q;
	logic [8:0] glyph_count_q;
	logic [10:0] kern_count_q;
	logic [7:0] missing_spacing_q;

	glyph_entry_t glyph_mem [GLYPH_SLOTS];
	glyph_entry_t glyph_rdata_q;

	logic [7:0] letter_q;
	logic [7:0] letter2_q;
	logic ok2_q;
	logic [8:0] index_q;
	logic [7:0] width_q;
	logic [9:0] spacing_q;
	logic applied_q;

	logic out_valid_q;
	logic [8:0] out_index_q;
	logic [7:0] out_width_q;
	logic [9:0] out_spacing_q;
	logic out_applied_q;

	logic in_acc;
	logic [8:0] gcount;
	logic [KC_W-1:0] kcount;
	logic [7:0] letter;
	logic [7:0] letter2;
	logic in_font;
	logic in_font2;
	logic glyph_wr;
	logic glyph_rd;
	logic kern_go;
	logic out_free;

	kern_wr_t kwr;
	scan_req_t sreq;
	scan_res_t sres;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign glyph_index = $signed(out_index_q);
	assign char_width = out_width_q;
	assign char_spacing = $signed(out_spacing_q);
	assign kern_applied = out_applied_q;

	always_comb begin
		gcount = (32'(glyph_count_q) < GLYPH_SLOTS) ? glyph_count_q : 9'(GLYPH_SLOTS);
		kcount = (32'(kern_count_q) < KERN_SLOTS) ? KC_W'(kern_count_q) : KC_W'(KERN_SLOTS);
		letter = first_char - first_code_q;
		letter2 = next_char - first_code_q;
		in_font = (first_char >= first_code_q) && ({1'b0, letter} < gcount);
		in_font2 = (next_char >= first_code_q) && ({1'b0, letter2} < gcount);
		glyph_wr = in_acc && (opcode == OP_GLYPH_WR) && (32'(entry_index) < GLYPH_SLOTS);
		glyph_rd = in_acc && (opcode == OP_QUERY) && in_font;
		kern_go = glyph_rdata_q.has_kern && ok2_q &&
			(PTR_W'(glyph_rdata_q.kern_start) < PTR_W'(kcount));

		kwr.en = in_acc && (opcode == OP_KERN_WR) && (32'(entry_index) < KERN_SLOTS);
		kwr.addr = entry_index;
		kwr.entry.first = pair_first;
		kwr.entry.second = pair_second;
		kwr.entry.offset = pair_offset;

		sreq.load = (state_q == ST_GLYPH) && kern_go;
		sreq.start = glyph_rdata_q.kern_start;
		sreq.letter = letter_q;
		sreq.letter2 = letter2_q;
		sreq.kcount = kcount;
	end

	gakl_kern_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (kwr),
		.req    (sreq),
		.res    (sres)
	);

	always_ff @(posedge clk) begin
		if (glyph_wr) begin
			glyph_mem[GLYPH_AW'(entry_index)] <= '{
				width: glyph_width,
				spacing: glyph_spacing,
				has_kern: glyph_has_kern,
				kern_start: glyph_kern_start
			};
		end
		if (glyph_rd) begin
			glyph_rdata_q <= glyph_mem[letter[GLYPH_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q <= '0;
			glyph_count_q <= '0;
			kern_count_q <= '0;
			missing_spacing_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_CODE: first_code_q <= cfg_data[7:0];
				REG_GLYPH_COUNT: glyph_count_q <= cfg_data[8:0];
				REG_KERN_COUNT: kern_count_q <= cfg_data;
				REG_MISSING_SPACING: missing_spacing_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (opcode == OP_QUERY)) begin
					letter_q <= letter;
					letter2_q <= letter2;
					ok2_q <= (next_char != CHAR_NUL) && (next_char != CHAR_NEWLINE) &&
						in_font2;
					applied_q <= 1'b0;
					if (in_font) begin
						index_q <= {1'b0, letter};
					end else begin
						index_q <= GLYPH_NONE;
						width_q <= '0;
						spacing_q <= {2'b00, missing_spacing_q};
					end
				end
			end
			ST_GLYPH: begin
				width_q <= glyph_rdata_q.width;
				spacing_q <= {2'b00, glyph_rdata_q.spacing};
			end
			ST_SCAN: begin
				if (sres.done && sres.hit) begin
					spacing_q <= spacing_q + {{2{sres.offset[7]}}, sres.offset};
					applied_q <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_index_q <= index_q;
					out_width_q <= width_q;
					out_spacing_q <= spacing_q;
					out_applied_q <= applied_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (opcode == OP_QUERY)) begin
						state_q <= in_font ? ST_GLYPH : ST_DONE;
					end
				end
				ST_GLYPH: begin
					state_q <= kern_go ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (sres.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/gakl_kern_scan.sv @@
// Kerning pair table and the scan unit that steps through one glyph's run of pairs.
module gakl_kern_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  gakl_pkg::kern_wr_t  wr,
	input  gakl_pkg::scan_req_t req,
	output gakl_pkg::scan_res_t res
);
	import gakl_pkg::*;

	kern_entry_t mem [KERN_SLOTS];
	kern_entry_t rdata_q;
	logic [PTR_W-1:0] ptr_q;
	logic active_q;

	logic [PTR_W-1:0] kcount;
	logic [PTR_W-1:0] nxt_ptr;
	logic in_range;
	logic cont;
	logic step;
	logic rd_en;

	always_comb begin
		kcount = PTR_W'(req.kcount);
		in_range = ptr_q < kcount;
		cont = active_q && in_range && (rdata_q.first == req.letter) &&
			(rdata_q.second < req.letter2);
		step = req.load || cont;
		nxt_ptr = req.load ? PTR_W'(req.start) : ptr_q + PTR_W'(1);
		rd_en = step && (nxt_ptr < kcount);
		res.done = active_q && !cont;
		res.hit = active_q && in_range && (rdata_q.second == req.letter2);
		res.offset = rdata_q.offset;
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[KERN_AW'(wr.addr)] <= wr.entry;
		end
		if (rd_en) begin
			rdata_q <= mem[nxt_ptr[KERN_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			active_q <= 1'b0;
		end else begin
			if (step) begin
				ptr_q <= nxt_ptr;
			end
			if (req.load) begin
				active_q <= 1'b1;
			end else if (res.done) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule
